@@ hdl/ima_adpcm_block_decoder_macros.svh @@
// Assertion macros for the IMA ADPCM block decoder.
`ifndef IMA_ADPCM_BLOCK_DECODER_MACROS_SVH
`define IMA_ADPCM_BLOCK_DECODER_MACROS_SVH
`ifndef SYNTHESIS
`define IMADEC_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("imadec: invariant violated");
`define IMADEC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("imadec: implication violated");
`define IMADEC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("imadec: next-cycle check violated");
`else
`define IMADEC_ASSERT(lbl, cond)
`define IMADEC_ASSERT_IMP(lbl, ante, cons)
`define IMADEC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ hdl/imadec_pkg.sv @@
// Shared types, tables and constants of the IMA ADPCM block decoder.
`timescale 1ns / 1ps
package imadec_pkg;

    localparam logic [6:0] INDEX_TOP = 7'd88;
    localparam int unsigned HDR_BYTES = 4;
    localparam logic signed [17:0] PCM_MIN = -18'sd32768;
    localparam logic signed [17:0] PCM_MAX = 18'sd32767;

    typedef struct packed {
        logic signed [15:0] predictor;
        logic [6:0]         step_index;
    } t_chan_state;

    localparam logic [14:0] STEP_TAB [0:88] = '{
        15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14, 15'd16, 15'd17,
        15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31, 15'd34, 15'd37, 15'd41, 15'd45,
        15'd50, 15'd55, 15'd60, 15'd66, 15'd73, 15'd80, 15'd88, 15'd97, 15'd107, 15'd118,
        15'd130, 15'd143, 15'd157, 15'd173, 15'd190, 15'd209, 15'd230, 15'd253, 15'd279,
        15'd307, 15'd337, 15'd371, 15'd408, 15'd449, 15'd494, 15'd544, 15'd598, 15'd658,
        15'd724, 15'd796, 15'd876, 15'd963, 15'd1060, 15'd1166, 15'd1282, 15'd1411,
        15'd1552, 15'd1707, 15'd1878, 15'd2066, 15'd2272, 15'd2499, 15'd2749, 15'd3024,
        15'd3327, 15'd3660, 15'd4026, 15'd4428, 15'd4871, 15'd5358, 15'd5894, 15'd6484,
        15'd7132, 15'd7845, 15'd8630, 15'd9493, 15'd10442, 15'd11487, 15'd12635,
        15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623,
        15'd27086, 15'd29794, 15'd32767
    };

    localparam logic signed [4:0] IDX_ADJ [0:15] = '{
        -5'sd1, -5'sd1, -5'sd1, -5'sd1, 5'sd2, 5'sd4, 5'sd6, 5'sd8,
        -5'sd1, -5'sd1, -5'sd1, -5'sd1, 5'sd2, 5'sd4, 5'sd6, 5'sd8
    };

endpackage

@@ hdl/ima_adpcm_block_decoder.sv @@
// IMA ADPCM block decoder: WAV block bytes in, 16-bit PCM samples out.
// A byte is registered on acceptance; its results are registered again at the output.
// A data byte gives two samples, one per cycle through the shared nibble decoder while
// the output is not stalled; a header byte without a result needs no second step.
// Reset (synchronous, active low) clears predictors, indexes and block position;
// channel count resets to mono.
`timescale 1ns / 1ps
`include "ima_adpcm_block_decoder_macros.svh"
module ima_adpcm_block_decoder #(
    parameter int MAX_CHANNELS = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [1:0]         i_cfg_wr_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_data_byte,
    input  logic               i_block_start,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_sample,
    output logic               o_channel,
    output logic               o_status,
    output logic               o_last
);

    localparam bit STEREO_OK = (MAX_CHANNELS >= 2);

    typedef enum logic [1:0] {
        PH_FIRST,
        PH_HIGH_NIBBLE,
        PH_RIGHT_HDR
    } t_phase;

    t_phase r_phase, n_phase;

    logic [1:0] r_chan_count;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_start;

    logic signed [15:0] r_pred [MAX_CHANNELS];
    logic [6:0]         r_idx  [MAX_CHANNELS];
    logic [7:0]         r_low;
    logic [3:0]         r_pos, n_pos;
    logic               r_data, n_data;
    logic               r_gc, n_gc;
    logic               r_err, n_err;

    logic               r_out_valid;
    logic signed [15:0] r_out_sample;
    logic               r_out_channel;
    logic               r_out_status;
    logic               r_out_last;

    logic               stereo;
    logic               clr;
    logic [3:0]         e_pos;
    logic               e_data, e_gc, e_err;
    logic               hdr_ch, dat_ch, rd_ch;
    logic [4:0]         pos_inc;
    logic [3:0]         grp_inc;

    logic               emit, done, fire, can_emit;
    logic signed [15:0] n_sample;
    logic               n_channel, n_status, n_last;
    logic               low_we, pred_we, idx_we, dec_we;
    logic signed [15:0] pred_wdata;
    logic [6:0]         idx_wdata;

    imadec_pkg::t_chan_state dec_in, dec_out;
    logic [3:0]              dec_code;

    assign stereo = STEREO_OK && r_chan_count[1];
    // block_start takes effect with the first step of its word only
    assign clr    = (r_phase == PH_FIRST) && r_in_start;
    assign e_pos  = clr ? 4'd0 : r_pos;
    assign e_data = clr ? 1'b0 : r_data;
    assign e_gc   = clr ? 1'b0 : r_gc;
    assign e_err  = clr ? 1'b0 : r_err;
    assign hdr_ch = stereo && e_pos[2];
    assign dat_ch = stereo && e_gc;
    assign rd_ch  = (r_phase == PH_RIGHT_HDR) ? 1'b1 : dat_ch;
    assign pos_inc = {1'b0, e_pos} + 5'd1;
    assign grp_inc = r_pos + 4'd1;

    assign dec_code         = (r_phase == PH_HIGH_NIBBLE) ? r_in_byte[7:4] : r_in_byte[3:0];
    assign dec_in.predictor  = r_pred[dat_ch];
    assign dec_in.step_index = r_idx[dat_ch];

    imadec_nibble u_nibble (
        .i_state (dec_in),
        .i_code  (dec_code),
        .o_state (dec_out)
    );

    always_comb begin
        emit       = 1'b0;
        done       = 1'b1;
        n_phase    = PH_FIRST;
        n_pos      = e_pos;
        n_data     = e_data;
        n_gc       = e_gc;
        n_err      = e_err;
        n_sample   = dec_out.predictor;
        n_channel  = dat_ch;
        n_status   = 1'b0;
        n_last     = 1'b0;
        low_we     = 1'b0;
        pred_we    = 1'b0;
        idx_we     = 1'b0;
        dec_we     = 1'b0;
        pred_wdata = $signed({r_in_byte, r_low});
        idx_wdata  = (r_in_byte > {1'b0, imadec_pkg::INDEX_TOP}) ? imadec_pkg::INDEX_TOP
                                                                 : r_in_byte[6:0];
        unique case (r_phase)
            PH_FIRST: begin
                if (e_err) begin
                    // rest of a failed block is dropped
                end else if (!e_data) begin
                    n_pos = pos_inc[3:0];
                    case (e_pos[1:0])
                        2'd0: low_we  = 1'b1;
                        2'd1: pred_we = 1'b1;
                        2'd2: idx_we  = 1'b1;
                        default: begin
                            if (r_in_byte != 8'd0) begin
                                emit      = 1'b1;
                                n_err     = 1'b1;
                                n_pos     = e_pos;
                                n_sample  = 16'sd0;
                                n_channel = hdr_ch;
                                n_status  = 1'b1;
                                n_last    = 1'b1;
                            end else if (pos_inc >= 5'(imadec_pkg::HDR_BYTES *
                                                      (stereo ? 2 : 1))) begin
                                emit      = 1'b1;
                                n_data    = 1'b1;
                                n_pos     = 4'd0;
                                n_gc      = 1'b0;
                                n_sample  = r_pred[0];
                                n_channel = 1'b0;
                                n_last    = !stereo;
                                if (stereo) begin
                                    done    = 1'b0;
                                    n_phase = PH_RIGHT_HDR;
                                end
                            end
                        end
                    endcase
                end else begin
                    emit    = 1'b1;
                    dec_we  = 1'b1;
                    done    = 1'b0;
                    n_phase = PH_HIGH_NIBBLE;
                end
            end
            PH_HIGH_NIBBLE: begin
                emit   = 1'b1;
                dec_we = 1'b1;
                n_last = 1'b1;
                if (stereo) begin
                    if (grp_inc >= 4'(imadec_pkg::HDR_BYTES)) begin
                        n_pos = 4'd0;
                        n_gc  = !r_gc;
                    end else begin
                        n_pos = grp_inc;
                    end
                end
            end
            PH_RIGHT_HDR: begin
                emit      = 1'b1;
                n_sample  = r_pred[rd_ch];
                n_channel = 1'b1;
                n_last    = 1'b1;
            end
            default: begin
                done = 1'b1;
            end
        endcase
    end

    assign can_emit = !r_out_valid || !i_stall;
    assign fire     = r_in_valid && (!emit || can_emit);
    assign o_stall  = r_in_valid && !(fire && done);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_FIRST;
            r_chan_count <= 2'd1;
            r_in_valid   <= 1'b0;
            r_in_byte    <= 8'd0;
            r_in_start   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_low        <= 8'd0;
            r_pos        <= 4'd0;
            r_data       <= 1'b0;
            r_gc         <= 1'b0;
            r_err        <= 1'b0;
            for (int c = 0; c < MAX_CHANNELS; c++) begin
                r_pred[c] <= 16'sd0;
                r_idx[c]  <= 7'd0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                r_chan_count <= i_cfg_wr_data;
            end

            if (i_valid && !o_stall) begin
                r_in_valid <= 1'b1;
                r_in_byte  <= i_data_byte;
                r_in_start <= i_block_start;
            end else if (fire && done) begin
                r_in_valid <= 1'b0;
            end

            if (fire) begin
                r_phase <= n_phase;
                r_pos   <= n_pos;
                r_data  <= n_data;
                r_gc    <= n_gc;
                r_err   <= n_err;
                if (low_we) begin
                    r_low <= r_in_byte;
                end
                if (pred_we) begin
                    r_pred[hdr_ch] <= pred_wdata;
                end
                if (idx_we) begin
                    r_idx[hdr_ch] <= idx_wdata;
                end
                if (dec_we) begin
                    r_pred[dat_ch] <= dec_out.predictor;
                    r_idx[dat_ch]  <= dec_out.step_index;
                end
            end

            if (fire && emit) begin
                r_out_valid   <= 1'b1;
                r_out_sample  <= n_sample;
                r_out_channel <= n_channel;
                r_out_status  <= n_status;
                r_out_last    <= n_last;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid   = r_out_valid;
    assign o_sample  = r_out_sample;
    assign o_channel = r_out_channel;
    assign o_status  = r_out_status;
    assign o_last    = r_out_last;

    `IMADEC_ASSERT(a_dec_index_range, dec_out.step_index <= imadec_pkg::INDEX_TOP)
    `IMADEC_ASSERT_IMP(a_second_step_has_word, r_phase != PH_FIRST, r_in_valid)
    `IMADEC_ASSERT_NEXT(a_second_result_last, fire && emit && r_phase != PH_FIRST,
                        r_out_valid && r_out_last)
    `IMADEC_ASSERT_IMP(a_error_is_last, o_valid && o_status, o_last && o_sample == 16'sd0)

endmodule

@@ hdl/imadec_nibble.sv @@
// One 4-bit IMA ADPCM code: step lookup, scaled difference, clamped update.
`timescale 1ns / 1ps
module imadec_nibble (
    input  imadec_pkg::t_chan_state i_state,
    input  logic [3:0]              i_code,
    output imadec_pkg::t_chan_state o_state
);

    logic [6:0]         idx_c;
    logic [14:0]        step;
    logic [3:0]         mult;
    logic [18:0]        prod;
    logic [15:0]        diff;
    logic signed [17:0] pred_x;
    logic signed [17:0] sum;
    logic signed [7:0]  idx_n;

    always_comb begin
        idx_c = (i_state.step_index > imadec_pkg::INDEX_TOP) ? imadec_pkg::INDEX_TOP
                                                             : i_state.step_index;
        step  = imadec_pkg::STEP_TAB[idx_c];
        mult  = {i_code[2:0], 1'b1};
        prod  = 19'(step) * 19'(mult);
        diff  = prod[18:3];
        pred_x = 18'(i_state.predictor);
        if (i_code[3]) begin
            sum = pred_x - $signed({2'b00, diff});
        end else begin
            sum = pred_x + $signed({2'b00, diff});
        end
        if (sum < imadec_pkg::PCM_MIN) begin
            o_state.predictor = 16'sh8000;
        end else if (sum > imadec_pkg::PCM_MAX) begin
            o_state.predictor = 16'sh7FFF;
        end else begin
            o_state.predictor = sum[15:0];
        end

        idx_n = $signed({1'b0, idx_c}) + 8'(imadec_pkg::IDX_ADJ[i_code]);
        if (idx_n < 8'sd0) begin
            o_state.step_index = 7'd0;
        end else if (idx_n > $signed({1'b0, imadec_pkg::INDEX_TOP})) begin
            o_state.step_index = imadec_pkg::INDEX_TOP;
        end else begin
            o_state.step_index = idx_n[6:0];
        end
    end

endmodule
